/* design/ccsfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccsfl_pkg
// Types and codes shared by the cons cell store and its free-list allocator.
// ----------------------------------------------------------------------------
package ccsfl_pkg;

    localparam int WORD_W   = 32;
    localparam int CMD_W    = 3;
    localparam int CIDX_W   = 10;
    localparam int SEL_W    = 2;
    localparam int AIDX_W   = 11;
    localparam int ERR_W    = 3;
    localparam int LIMIT_W  = 11;
    localparam int TDATA_W  = 48;
    localparam int APB_AW   = 2;
    localparam int APB_DW   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

    // Commands
    localparam logic [CMD_W-1:0] CMD_ALLOC = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INC   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DEC   = 3'd5;

    // Field selects
    localparam logic [SEL_W-1:0] FLD_CAR = 2'd0;
    localparam logic [SEL_W-1:0] FLD_CDR = 2'd1;
    localparam logic [SEL_W-1:0] FLD_TAG = 2'd2;
    localparam logic [SEL_W-1:0] FLD_REF = 2'd3;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_OK       = 3'd0;
    localparam logic [ERR_W-1:0] ERR_NO_CELLS = 3'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_UNINIT   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DOUBLE   = 3'd4;

    // Tag codes
    localparam logic [WORD_W-1:0] CELL_UNINIT = 32'd0;
    localparam logic [WORD_W-1:0] CELL_ATOM   = 32'd1;
    localparam logic [WORD_W-1:0] CELL_FREED  = 32'd2;

    // Register index of the cell limit
    localparam int REG_CELL_LIMIT = 0;

    // One row of the store holds all four words of a cell.
    typedef struct packed {
        logic [WORD_W-1:0] refcount;
        logic [WORD_W-1:0] tag;
        logic [WORD_W-1:0] cdr;
        logic [WORD_W-1:0] car;
    } cell_row_t;

endpackage

/* design/cons_cell_store_free_list_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cons_cell_store_free_list_core
// Cons cell store with a free-list allocator, kept in one row-wide memory.
// ----------------------------------------------------------------------------
// Usage:
// Commands arrive on the s_ stream channel, one transaction per command, and
// each one yields exactly one result transaction on the m_ channel carrying
// the allocated index, the read word and an error code. The cell limit is
// to be written through the APB port only while the block is idle; the
// block itself does not enforce this.
// Each command reads the addressed cell row from the store in the cycle it is
// accepted and writes the modified row back in its write-back state, when the
// result is loaded into the output register. No new command is accepted until
// the previous one has finished its write-back; this is set by the single
// read-modify-write of the store, since an allocate must see the popped cell's
// car before the free-list head moves.
// A new command is accepted while a finished result still waits in the output
// register; if the receiver stalls, the next command holds in its write-back
// cycle until the output register frees up.
// After reset the block sweeps every row of the store to zero, one row per
// cycle, and holds s_tready low meanwhile. APB writes are taken during the
// sweep.
// ----------------------------------------------------------------------------
module cons_cell_store_free_list_core #(
    parameter int MAX_CELLS = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // command [2:0], cell_index [12:3], field_select [14:13],
    // write_value [46:15], zero [47]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ccsfl_pkg::TDATA_W-1:0] s_tdata,
    // alloc_index [10:0], read_value [42:11], error [45:43], zero [47:46]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ccsfl_pkg::TDATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ccsfl_pkg::APB_AW-1:0]  paddr,
    input  logic [ccsfl_pkg::APB_DW-1:0]  pwdata,
    output logic [ccsfl_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import ccsfl_pkg::*;

    localparam int IDX_W = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam int CMP_W = (IDX_W + 1 > LIMIT_W) ? IDX_W + 1 : LIMIT_W;
    localparam logic [CMP_W-1:0] MAX_CMP   = CMP_W'(MAX_CELLS);
    localparam logic [WORD_W-1:0] MAX_WORD = WORD_W'(MAX_CELLS);
    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_CELLS - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // Input fields
    logic [CMD_W-1:0]  s_command;
    logic [CIDX_W-1:0] s_cell_index;
    logic [SEL_W-1:0]  s_field_select;
    logic [WORD_W-1:0] s_write_value;

    assign s_command      = s_tdata[2:0];
    assign s_cell_index   = s_tdata[12:3];
    assign s_field_select = s_tdata[14:13];
    assign s_write_value  = s_tdata[46:15];

    // Control and configuration state
    logic                state_reg, state_next;
    logic                clr_busy_reg;
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [LIMIT_W-1:0]  cell_limit_reg;
    logic                fh_valid_reg, fh_valid_next;
    logic [IDX_W-1:0]    fh_idx_reg, fh_idx_next;
    logic [IDX_W:0]      next_fresh_reg, next_fresh_next;

    // Command held across the write-back state
    logic [CMD_W-1:0]    cmd_reg;
    logic [SEL_W-1:0]    sel_reg;
    logic [WORD_W-1:0]   wval_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [ERR_W-1:0]    pre_err_reg;

    // Output register
    logic                m_tvalid_reg;
    logic [TDATA_W-1:0]  m_tdata_reg;

    // Store
    cell_row_t           mem [MAX_CELLS];
    cell_row_t           rdata_reg;
    cell_row_t           wrow;
    logic                row_we;

    logic                s_accept;
    logic                exec_done;
    logic [CMP_W-1:0]    cfg_ext;
    logic [CMP_W-1:0]    lim;
    logic [IDX_W-1:0]    rd_addr;
    logic [ERR_W-1:0]    pre_err;
    logic [ERR_W-1:0]    err;
    logic                got_valid;
    logic [WORD_W-1:0]   got_word;
    logic [WORD_W-1:0]   rd_word;
    logic [WORD_W-1:0]   link;
    logic [AIDX_W-1:0]   alloc_index;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign prdata = APB_DW'(cell_limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready) begin
            cell_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    assign cfg_ext = CMP_W'(cell_limit_reg);
    assign lim     = (cfg_ext > MAX_CMP) ? MAX_CMP : cfg_ext;

    // ------------------------------------------------------------------
    // Accept: pick the row to read and settle the errors known up front
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign exec_done = (state_reg == ST_EXEC) && (!m_tvalid_reg || m_tready);

    always_comb begin
        rd_addr = IDX_W'(s_cell_index);
        pre_err = ERR_OK;
        if (s_command == CMD_ALLOC) begin
            if (fh_valid_reg) begin
                rd_addr = fh_idx_reg;
                if (CMP_W'(fh_idx_reg) >= lim) begin
                    pre_err = ERR_RANGE;
                end
            end else begin
                rd_addr = next_fresh_reg[IDX_W-1:0];
                if (CMP_W'(next_fresh_reg) >= lim) begin
                    pre_err = ERR_NO_CELLS;
                end
            end
        end else if (s_command <= CMD_DEC) begin
            if (CMP_W'(s_cell_index) >= lim) begin
                pre_err = ERR_RANGE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg     <= s_command;
            sel_reg     <= s_field_select;
            wval_reg    <= s_write_value;
            addr_reg    <= rd_addr;
            pre_err_reg <= pre_err;
        end
    end

    // ------------------------------------------------------------------
    // Write-back: modify the row read when the command was accepted
    // ------------------------------------------------------------------
    assign link     = rdata_reg.car;
    assign got_word = WORD_W'(addr_reg);

    always_comb begin
        wrow            = rdata_reg;
        row_we          = 1'b0;
        err             = pre_err_reg;
        got_valid       = 1'b0;
        rd_word         = '0;
        fh_valid_next   = fh_valid_reg;
        fh_idx_next     = fh_idx_reg;
        next_fresh_next = next_fresh_reg;
        if (pre_err_reg == ERR_OK) begin
            case (cmd_reg)
                CMD_ALLOC: begin
                    row_we        = 1'b1;
                    got_valid     = 1'b1;
                    wrow.car      = '1;
                    wrow.tag      = CELL_ATOM;
                    wrow.refcount = '0;
                    if (fh_valid_reg) begin
                        // A link that names no cell empties the stack.
                        if (link != '1 && link < MAX_WORD) begin
                            fh_idx_next = link[IDX_W-1:0];
                        end else begin
                            fh_valid_next = 1'b0;
                        end
                    end else begin
                        next_fresh_next = next_fresh_reg + 1'b1;
                    end
                end
                CMD_FREE: begin
                    if (rdata_reg.tag == CELL_UNINIT) begin
                        err = ERR_UNINIT;
                    end else if (rdata_reg.tag == CELL_FREED) begin
                        err = ERR_DOUBLE;
                    end else begin
                        row_we        = 1'b1;
                        wrow.tag      = CELL_FREED;
                        wrow.car      = fh_valid_reg ? WORD_W'(fh_idx_reg) : '1;
                        fh_valid_next = 1'b1;
                        fh_idx_next   = addr_reg;
                    end
                end
                CMD_READ: begin
                    case (sel_reg)
                        FLD_CAR: rd_word = rdata_reg.car;
                        FLD_CDR: rd_word = rdata_reg.cdr;
                        FLD_TAG: rd_word = rdata_reg.tag;
                        default: rd_word = rdata_reg.refcount;
                    endcase
                end
                CMD_WRITE: begin
                    row_we = 1'b1;
                    case (sel_reg)
                        FLD_CAR: wrow.car      = wval_reg;
                        FLD_CDR: wrow.cdr      = wval_reg;
                        FLD_TAG: wrow.tag      = wval_reg;
                        default: wrow.refcount = wval_reg;
                    endcase
                end
                CMD_INC: begin
                    row_we        = 1'b1;
                    wrow.refcount = rdata_reg.refcount + 1'b1;
                end
                CMD_DEC: begin
                    row_we        = 1'b1;
                    wrow.refcount = rdata_reg.refcount - 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign alloc_index = got_valid ? got_word[AIDX_W-1:0] : '1;

    // ------------------------------------------------------------------
    // Store: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_addr_reg] <= '0;
        end else if (exec_done && row_we) begin
            mem[addr_reg] <= wrow;
        end
        if (s_accept) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Sequencer, allocator state and clearing sweep
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (exec_done) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clr_busy_reg   <= 1'b1;
            clr_addr_reg   <= '0;
            fh_valid_reg   <= 1'b0;
            fh_idx_reg     <= '0;
            next_fresh_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (clr_busy_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == LAST_ADDR) begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (exec_done) begin
                fh_valid_reg   <= fh_valid_next;
                fh_idx_reg     <= fh_idx_next;
                next_fresh_reg <= next_fresh_next;
                m_tvalid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_done) begin
            m_tdata_reg <= {2'b00, err, rd_word, alloc_index};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !s_accept)
        else $error("command accepted during the clearing sweep");

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg == ST_EXEC))
        else $error("accepted command did not reach write-back");

    a_no_write_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec_done && err != ERR_OK) |-> !row_we)
        else $error("store written by a failing command");

    a_result_follows_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        exec_done |=> m_tvalid_reg)
        else $error("finished command produced no result");

endmodule
